>>> rtl/olpp_pkg.sv
// ----------------------------------------------------------------------------
// Oximeter live packet parser package
// Shared constants, payload types and the signal strength scaling table.
// ----------------------------------------------------------------------------
package olpp_pkg;

   localparam logic [7:0]  TypeLive       = 8'h01;
   localparam int          BodyLen        = 7;
   localparam logic [3:0]  SigMin         = 4'd4;
   localparam logic [3:0]  SigMax         = 4'd10;
   localparam logic [15:0] RerequestReset = 16'd900;

   typedef struct packed {
      logic [6:0]  signal_percent;
      logic        beep;
      logic        finger_off;
      logic        search_too_long;
      logic        pulse_search;
      logic [6:0]  wave_point;
      logic        perfusion_valid;
      logic [7:0]  heart_rate;
      logic [7:0]  oxygen_saturation;
      logic [15:0] perf_index;
      logic [15:0] delta_ms;
      logic        request_again;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } pkt_type;

   // Strength nibble clamped to 4..10, then (s - 4) * 100 / 6 truncated.
   function automatic logic [6:0] signal_percent_of(input logic [3:0] nib);
      logic [6:0] pct;
      unique case (nib)
         4'd5:    pct = 7'd16;
         4'd6:    pct = 7'd33;
         4'd7:    pct = 7'd50;
         4'd8:    pct = 7'd66;
         4'd9:    pct = 7'd83;
         4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15: pct = 7'd100;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

endpackage

>>> rtl/olpp_channels.sv
// ----------------------------------------------------------------------------
// Oximeter live packet parser channels
// Valid/ready interfaces for the byte input, result output and register port.
// ----------------------------------------------------------------------------
interface olpp_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;

   modport source (output valid, mode, rx_byte, now_ms, input ready);
   modport sink   (input valid, mode, rx_byte, now_ms, output ready);
endinterface

interface olpp_rsp_if;
   logic                 valid;
   logic                 ready;
   olpp_pkg::result_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

interface olpp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/olpp_parse.sv
// ----------------------------------------------------------------------------
// Oximeter live packet parser framing
// Byte state machine, body buffer, packet timing and re-request counter.
// ----------------------------------------------------------------------------
module olpp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat_accept,
   input  logic               mode,
   input  logic [7:0]         rx_byte,
   input  logic [31:0]        now_ms,
   input  logic [15:0]        rerequest_count,
   output olpp_pkg::pkt_type  pkt
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_HIGH   = 2'd1;
   localparam logic [1:0] ST_BODY   = 2'd2;
   localparam logic [1:0] ST_CLOSED = 2'd3;

   localparam logic [2:0] BodyLen3 = 3'(olpp_pkg::BodyLen);

   logic [1:0]  state_ff, state_in;
   logic [6:0]  hb_ff, hb_in;
   logic [2:0]  rem_ff, rem_in;
   logic [15:0] last_ff, last_in;
   logic [15:0] count_ff, count_in;
   logic [6:0]  body_ff [0:olpp_pkg::BodyLen-2];

   logic [2:0]  rem_eff;
   logic [2:0]  idx;
   logic        wr_en;
   logic        done;
   logic [16:0] cnt_next;
   logic        req_again;
   logic [3:0]  nib;

   assign rem_eff   = (rem_ff == 3'd0) ? BodyLen3 : rem_ff;
   assign idx       = BodyLen3 - rem_eff;
   assign cnt_next  = {1'b0, count_ff} + 17'd1;
   assign req_again = cnt_next > {1'b0, rerequest_count};

   always_comb begin
      state_in = state_ff;
      hb_in    = hb_ff;
      rem_in   = rem_ff;
      last_in  = last_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      done     = 1'b0;
      if (beat_accept && state_ff != ST_CLOSED) begin
         if (mode) begin
            state_in = ST_CLOSED;
         end else begin
            unique case (state_ff)
               ST_IDLE, ST_HIGH: begin
                  if (!rx_byte[7]) begin
                     if (rx_byte == olpp_pkg::TypeLive) begin
                        state_in = ST_HIGH;
                        rem_in   = BodyLen3;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end else if (state_ff == ST_HIGH) begin
                     hb_in    = rx_byte[6:0];
                     state_in = ST_BODY;
                  end
               end
               default: begin
                  rem_in = rem_eff - 3'd1;
                  if (rem_eff == 3'd1) begin
                     done     = 1'b1;
                     state_in = ST_IDLE;
                     last_in  = now_ms[15:0];
                     count_in = req_again ? 16'd0 : cnt_next[15:0];
                  end else begin
                     wr_en = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // The last body byte comes straight from the beat; the rest from the buffer.
   always_comb begin
      nib = body_ff[0][3:0];
      if (nib < olpp_pkg::SigMin) nib = olpp_pkg::SigMin;
      if (nib > olpp_pkg::SigMax) nib = olpp_pkg::SigMax;
      pkt.valid                  = done;
      pkt.data.signal_percent    = olpp_pkg::signal_percent_of(nib);
      pkt.data.beep              = body_ff[0][6];
      pkt.data.finger_off        = hb_ff[0];
      pkt.data.search_too_long   = body_ff[0][4];
      pkt.data.pulse_search      = hb_ff[1];
      pkt.data.wave_point        = body_ff[1];
      pkt.data.perfusion_valid   = !body_ff[2][4];
      pkt.data.heart_rate        = {hb_ff[3], body_ff[3]};
      pkt.data.oxygen_saturation = {hb_ff[4], body_ff[4]};
      pkt.data.perf_index        = {hb_ff[6], rx_byte[6:0], hb_ff[5], body_ff[5]};
      pkt.data.delta_ms          = now_ms[15:0] - last_ff;
      pkt.data.request_again     = req_again;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hb_ff    <= '0;
         rem_ff   <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         hb_ff    <= hb_in;
         rem_ff   <= rem_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         body_ff[idx] <= rx_byte[6:0];
      end
   end

`ifndef SYNTHESIS
   a_done_from_body: assert property (@(posedge clock) disable iff (reset)
      pkt.valid |-> state_ff == ST_BODY)
      else $error("packet completed outside the body state");
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLOSED |=> state_ff == ST_CLOSED)
      else $error("parser left the closed state");
   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      pkt.valid && pkt.data.request_again |=> count_ff == 16'd0)
      else $error("packet count not cleared after a re-request");
`endif

endmodule

>>> rtl/olpp_outq.sv
// ----------------------------------------------------------------------------
// Oximeter live packet parser result queue
// Output register with a skid stage so input beats keep flowing on a stall.
// ----------------------------------------------------------------------------
module olpp_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  olpp_pkg::pkt_type     in_pkt,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output olpp_pkg::result_type  out_data
);

   logic                 head_valid_ff, head_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   olpp_pkg::result_type head_ff, head_in;
   olpp_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign pop       = head_valid_ff && out_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_pkt.valid && head_valid_ff && !pop) begin
         skid_in       = in_pkt.data;
         skid_valid_in = 1'b1;
      end else if (in_pkt.valid) begin
         head_in       = in_pkt.data;
         head_valid_in = 1'b1;
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid stage holds a result while the output register is empty");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && !out_ready |=> head_valid_ff && $stable(head_ff))
      else $error("result changed while the output was stalled");
   a_in_has_room: assert property (@(posedge clock) disable iff (reset)
      in_pkt.valid |-> in_ready)
      else $error("result arrived with both slots full");
`endif

endmodule

>>> rtl/oximeter_live_packet_parser.sv
// Result path: a live packet is decoded from the beat that carries its last body
//   byte and registered in the output register, or in the skid stage on a stall.
// Throughput: one input beat per cycle, set by the parser and the
//   two-entry output queue; input stalls only when both result slots are full.
// Reset: synchronous, active high; the parser returns to idle, counters and the
//   stored time clear, and the re-request threshold returns to 900.
// ----------------------------------------------------------------------------
// Oximeter live packet parser
// Resynchronizing parser for live-data packets from a pulse oximeter byte
// stream, with packet timing and a periodic live-data re-request pulse.
// ----------------------------------------------------------------------------
module oximeter_live_packet_parser (
   input  logic       clock,
   input  logic       reset,
   olpp_req_if.sink   req_chan,
   olpp_rsp_if.source rsp_chan,
   olpp_csr_if.sink   csr_chan
);

   // Re-request threshold. Writes are always taken and not staged; the user is to
   // change it only while the parser is quiet, which the block does not enforce.
   logic [15:0] rerequest_ff, rerequest_in;

   olpp_pkg::pkt_type pkt;
   logic              q_ready;
   logic              beat_accept;

   assign csr_chan.ready = 1'b1;
   assign rerequest_in   = csr_chan.valid ? csr_chan.data : rerequest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rerequest_ff <= olpp_pkg::RerequestReset;
      end else begin
         rerequest_ff <= rerequest_in;
      end
   end

   // A beat is taken whenever the result queue has a free slot. Every beat,
   // including ones that produce no result, updates the parser unless it is closed.
   assign req_chan.ready = q_ready;
   assign beat_accept    = req_chan.valid && q_ready;

   // The parser state registers act as the input register: bytes before the
   // last body byte are folded into them, and the last body byte is decoded
   // together with the stored bytes into one result.
   olpp_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .beat_accept     (beat_accept),
      .mode            (req_chan.mode),
      .rx_byte         (req_chan.rx_byte),
      .now_ms          (req_chan.now_ms),
      .rerequest_count (rerequest_ff),
      .pkt             (pkt)
   );

   // The result register with its skid stage decouples the two sides, so a
   // stalled result does not hold up incoming bytes.
   olpp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_pkt    (pkt),
      .in_ready  (q_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.data)
   );

endmodule
